### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and codes for the double-ended queue
// Command and status codes, the stored entry word and the result word.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int KEY_W     = 32;
	localparam int LET_W     = 8;
	localparam int CMD_W     = 3;
	localparam int ST_W      = 2;
	localparam int ENTRY_W   = KEY_W + LET_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND_KEY   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIND_LET   = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [LET_W-1:0] letter;
	} entry_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		entry_t          entry;
	} res_t;

endpackage

### rtl/deq_with_linear_search_top.sv
// ----------------------------------------------------------------------------
// deque_with_linear_search_top: bounded double-ended queue with search
// Commands are taken only in the idle state, one at a time: a push goes from
// idle to done, a pop through a pop state and a search through a scan state.
// The result word then passes through the output register;
// the search walk reads the entry memory one word per cycle.
// Reset: arst_n empties the queue (front and count to zero) at once; memory
// contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module deque_with_linear_search_top import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [KEY_W-1:0] key,
	input  logic [LET_W-1:0]        letter,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ST_W-1:0]         status,
	output logic signed [KEY_W-1:0] out_key,
	output logic [LET_W-1:0]        out_letter,
	output logic [IW-1:0]           position,
	output logic [CW-1:0]           occupancy
);

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic [IW-1:0] res_pos;
	logic [CW-1:0] res_occ;
	logic          out_valid_q;
	res_t          out_res_q;
	logic [IW-1:0] out_pos_q;
	logic [CW-1:0] out_occ_q;

	deq_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.key       (key),
		.letter    (letter),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.res_pos   (res_pos),
		.res_occ   (res_occ)
	);

	// load the output register whenever it is empty or being drained
	assign res_ready = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the output word
	always_ff @(posedge clk) begin
		if (res_ready) begin
			out_res_q <= res;
			out_pos_q <= res_pos;
			out_occ_q <= res_occ;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_res_q.status;
	assign out_key    = out_res_q.entry.key;
	assign out_letter = out_res_q.entry.letter;
	assign position   = out_pos_q;
	assign occupancy  = out_occ_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= CW'(DEPTH)))
		else $error("occupancy above depth");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL)) |-> (occupancy == CW'(DEPTH)))
		else $error("full reported below depth");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_EMPTY)) |-> (occupancy == '0))
		else $error("empty reported with entries held");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_NOTFOUND || status == ST_EMPTY))
		|-> (out_key == '0 && out_letter == '0 && position == '0))
		else $error("miss word carries nonzero payload");

endmodule

### rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/deq_engine.sv
// ----------------------------------------------------------------------------
// deq_engine: command sequencer around the entry memory
// Keeps front pointer and count, writes pushes, reads pops, and walks the
// memory one entry per cycle for a search, comparing the returned word.
// ----------------------------------------------------------------------------
module deq_engine import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] cmd,
	input  logic [KEY_W-1:0] key,
	input  logic [LET_W-1:0] letter,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	output logic [IW-1:0]    res_pos,
	output logic [CW-1:0]    res_occ
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [IW:0]   DEPTH_X = (IW + 1)'(DEPTH);
	localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

	logic [1:0]       state_q;
	logic [IW-1:0]    front_q;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    rd_slot_q;
	logic [IW-1:0]    idx_s1;
	logic             last_s1;
	logic             by_key_q;
	logic [KEY_W-1:0] key_q;
	logic [LET_W-1:0] letter_q;
	res_t             res_q;
	logic [IW-1:0]    pos_q;

	logic             accept;
	logic             full;
	logic             empty;
	logic [IW:0]      count_x;
	logic [IW-1:0]    back_slot;
	logic [IW-1:0]    last_slot;
	logic [IW-1:0]    front_dec;
	logic [IW-1:0]    front_inc;
	logic [IW-1:0]    rd_inc;
	logic             match;
	logic             we;
	logic [IW-1:0]    waddr;
	logic [IW-1:0]    raddr;
	entry_t           wdata;
	entry_t           rdata;

	// fold a sum below twice the depth back into the ring
	function automatic logic [IW-1:0] wrap_idx(input logic [IW:0] s);
		logic [IW:0] t;
		t = (s >= DEPTH_X) ? (s - DEPTH_X) : s;
		return t[IW-1:0];
	endfunction

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign count_x   = (IW + 1)'(count_q);
	assign back_slot = wrap_idx({1'b0, front_q} + count_x);
	assign last_slot = wrap_idx({1'b0, front_q} + count_x - (IW + 1)'(1));
	assign front_dec = (front_q == '0) ? LAST_IX : (front_q - IW'(1));
	assign front_inc = wrap_idx({1'b0, front_q} + (IW + 1)'(1));
	assign rd_inc    = wrap_idx({1'b0, rd_slot_q} + (IW + 1)'(1));
	assign match     = by_key_q ? (rdata.key == key_q) : (rdata.letter == letter_q);

	// drive memory ports; pushes write only in the accept cycle and no command
	// reads in the cycle of a push, so no same-entry overlap needs forwarding
	always_comb begin
		we     = 1'b0;
		waddr  = back_slot;
		raddr  = rd_slot_q;
		wdata  = '{key: key, letter: letter};
		if (accept) begin
			case (cmd)
				CMD_PUSH_FRONT: begin
					we    = !full;
					waddr = front_dec;
				end
				CMD_PUSH_BACK: begin
					we    = !full;
					waddr = back_slot;
				end
				CMD_POP_FRONT: raddr = front_q;
				CMD_POP_BACK:  raddr = last_slot;
				CMD_FIND_KEY,
				CMD_FIND_LET:  raddr = front_q;
				default: ;
			endcase
		end
	end

	deq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// control: state, pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_PUSH_FRONT,
							CMD_PUSH_BACK: begin
								state_q <= S_DONE;
								if (!full) begin
									count_q <= count_q + CW'(1);
									if (cmd == CMD_PUSH_FRONT) begin
										front_q <= front_dec;
									end
								end
							end
							CMD_POP_FRONT,
							CMD_POP_BACK: begin
								if (!empty) begin
									state_q <= S_POP;
									count_q <= count_q - CW'(1);
									if (cmd == CMD_POP_FRONT) begin
										front_q <= front_inc;
									end
								end else begin
									state_q <= S_DONE;
								end
							end
							CMD_FIND_KEY,
							CMD_FIND_LET: begin
								state_q <= empty ? S_DONE : S_SCAN;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_POP: state_q <= S_DONE;
				S_SCAN: begin
					if (match || last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: search operands, scan pointers and the result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					by_key_q    <= (cmd == CMD_FIND_KEY);
					key_q       <= key;
					letter_q    <= letter;
					rd_slot_q   <= front_inc;
					idx_s1      <= '0;
					last_s1     <= (count_q == CW'(1));
					res_q.entry <= '0;
					pos_q       <= '0;
					case (cmd)
						CMD_PUSH_FRONT,
						CMD_PUSH_BACK: res_q.status <= full ? ST_FULL : ST_OK;
						CMD_POP_FRONT,
						CMD_POP_BACK:  res_q.status <= empty ? ST_EMPTY : ST_OK;
						CMD_FIND_KEY,
						CMD_FIND_LET:  res_q.status <= empty ? ST_NOTFOUND : ST_OK;
						default:       res_q.status <= ST_OK;
					endcase
				end
			end
			S_POP: res_q.entry <= rdata;
			S_SCAN: begin
				if (match) begin
					res_q.entry <= rdata;
					pos_q       <= idx_s1;
				end else if (last_s1) begin
					res_q.status <= ST_NOTFOUND;
				end else begin
					// advance the read pointer; the word on rdata is one entry behind it
					rd_slot_q <= rd_inc;
					idx_s1    <= idx_s1 + IW'(1);
					last_s1   <= (((IW + 1)'(idx_s1) + (IW + 1)'(2)) == count_x);
				end
			end
			default: ;
		endcase
	end

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign res_pos   = pos_q;
	assign res_occ   = count_q;

endmodule
